@@ rtl/wpb_pkg.sv @@
package wpb_pkg;

    // item operation codes
    typedef enum logic [2:0] {
        OP_SET   = 3'd0,
        OP_GET   = 3'd1,
        OP_CLEAR = 3'd2,
        OP_FLUSH = 3'd3,
        OP_TICK  = 3'd4
    } t_op;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ZERO_HIGH = 3'd0,
        CFG_ZERO_LOW  = 3'd1,
        CFG_ONE_HIGH  = 3'd2,
        CFG_ONE_LOW   = 3'd3,
        CFG_LATCH_GAP = 3'd4
    } t_cfg_idx;

    // line sender phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    localparam int unsigned PIX_BITS = 24;
    localparam int unsigned BIT_CNT_W = 5;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned DUR_W = 8;

    localparam logic [DUR_W-1:0]  RST_ZERO_HIGH = 8'd3;
    localparam logic [DUR_W-1:0]  RST_ZERO_LOW  = 8'd7;
    localparam logic [DUR_W-1:0]  RST_ONE_HIGH  = 8'd6;
    localparam logic [DUR_W-1:0]  RST_ONE_LOW   = 8'd4;
    localparam logic [TICK_W-1:0] RST_LATCH_GAP = 16'd480;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr;        // store the set item at its index
        logic clr;       // zero the whole store
        logic rd_a;      // read the get item's pixel
        logic start;     // load first pixel, restart counters
        logic tc_inc;    // advance the tick counter
        logic tc_clr;    // restart the tick counter
        logic bit_next;  // move to the next bit of this pixel
        logic pix_next;  // load the next pixel
    } t_cmd;

    // datapath status for the controller
    typedef struct packed {
        logic idx_ok;     // pixel index is inside the store
        logic hi_done;    // high time of the current bit reached
        logic lo_done;    // low time of the current bit reached
        logic gap_done;   // latch gap reached
        logic last_bit;   // current bit is the last of its pixel
        logic last_pix;   // current pixel is the last of the store
    } t_status;

    // result flags of one item
    typedef struct packed {
        logic line;
        logic dirty;
        logic busy;
        logic acc;
        logic show_read;
    } t_res;

endpackage

@@ rtl/wpb_ctrl.sv @@
module wpb_ctrl
    import wpb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [2:0] i_op,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output t_res       o_res
);

    t_phase r_phase, n_phase;
    logic   r_dirty, n_dirty;
    logic   r_line, n_line;
    logic   busy;

    assign busy = (r_phase != PH_IDLE);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_dirty <= 1'b0;
            r_line  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_dirty <= n_dirty;
            r_line  <= n_line;
        end
    end

    // item decode and sender sequencing
    always_comb begin
        n_phase         = r_phase;
        n_dirty         = r_dirty;
        n_line          = r_line;
        o_cmd           = '0;
        o_res.acc       = 1'b0;
        o_res.show_read = 1'b0;
        if (i_go) begin
            unique case (t_op'(i_op))
                OP_SET: begin
                    if (!busy && i_status.idx_ok) begin
                        o_cmd.wr  = 1'b1;
                        n_dirty   = 1'b1;
                        o_res.acc = 1'b1;
                    end
                end
                OP_GET: begin
                    if (i_status.idx_ok) begin
                        o_cmd.rd_a      = 1'b1;
                        o_res.acc       = 1'b1;
                        o_res.show_read = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    if (!busy) begin
                        o_cmd.clr = 1'b1;
                        n_dirty   = 1'b1;
                        o_res.acc = 1'b1;
                    end
                end
                OP_FLUSH: begin
                    if (!busy && r_dirty) begin
                        o_cmd.start = 1'b1;
                        n_phase     = PH_HIGH;
                        o_res.acc   = 1'b1;
                    end
                end
                OP_TICK: begin
                    o_res.acc = 1'b1;
                    unique case (r_phase)
                        PH_HIGH: begin
                            n_line = 1'b1;
                            if (i_status.hi_done) begin
                                o_cmd.tc_clr = 1'b1;
                                n_phase      = PH_LOW;
                            end else begin
                                o_cmd.tc_inc = 1'b1;
                            end
                        end
                        PH_LOW: begin
                            n_line = 1'b0;
                            if (i_status.lo_done) begin
                                o_cmd.tc_clr = 1'b1;
                                if (!i_status.last_bit) begin
                                    o_cmd.bit_next = 1'b1;
                                    n_phase        = PH_HIGH;
                                end else if (!i_status.last_pix) begin
                                    o_cmd.pix_next = 1'b1;
                                    n_phase        = PH_HIGH;
                                end else begin
                                    n_phase = PH_GAP;
                                end
                            end else begin
                                o_cmd.tc_inc = 1'b1;
                            end
                        end
                        PH_GAP: begin
                            n_line = 1'b0;
                            if (i_status.gap_done) begin
                                o_cmd.tc_clr = 1'b1;
                                n_phase      = PH_IDLE;
                                n_dirty      = 1'b0;
                            end else begin
                                o_cmd.tc_inc = 1'b1;
                            end
                        end
                        default: begin
                            n_line       = 1'b0;
                            o_cmd.tc_clr = 1'b1;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        o_res.line  = n_line;
        o_res.dirty = n_dirty;
        o_res.busy  = (n_phase != PH_IDLE);
    end

endmodule

@@ rtl/wpb_datapath.sv @@
module wpb_datapath
    import wpb_pkg::*;
#(
    parameter int unsigned PIXELS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_cfg_wr,
    input  logic [2:0]          i_cfg_index,
    input  logic [TICK_W-1:0]   i_cfg_data,
    input  logic [7:0]          i_pixel_index,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    output logic [PIX_BITS-1:0] o_rd_data
);

    localparam int unsigned PW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [8:0]    PIX_LIM = 9'(PIXELS);
    localparam logic [PW-1:0] PIX_LAST = PW'(PIXELS - 1);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(PIX_BITS - 1);

    logic [PIX_BITS-1:0]  r_mem [PIXELS];
    logic [PIXELS-1:0]    r_valid;
    logic [PIX_BITS-1:0]  r_rda;
    logic [PIX_BITS-1:0]  r_rdb;
    logic [DUR_W-1:0]     r_zero_high, r_zero_low, r_one_high, r_one_low;
    logic [TICK_W-1:0]    r_gap;
    logic [TICK_W-1:0]    r_tc, n_tc;
    logic [BIT_CNT_W-1:0] r_bitcnt;
    logic [PW-1:0]        r_pix;
    logic [PIX_BITS-1:0]  r_shift;
    logic [PW-1:0]        addr_a;
    logic [PW-1:0]        addr_b;
    logic [PIX_BITS-1:0]  wdata;
    logic                 cur_bit;
    logic [DUR_W-1:0]     hi_dur, lo_dur;

    assign addr_a = i_pixel_index[PW-1:0];
    assign wdata  = {i_red, i_green, i_blue};

    // prefetch address: the pixel after the current one; idle keeps the last
    // pixel selected, so the prefetch then points at pixel zero
    assign addr_b = (r_pix == PIX_LAST) ? '0 : r_pix + PW'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_high <= RST_ZERO_HIGH;
            r_zero_low  <= RST_ZERO_LOW;
            r_one_high  <= RST_ONE_HIGH;
            r_one_low   <= RST_ONE_LOW;
            r_gap       <= RST_LATCH_GAP;
        end else if (i_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ZERO_HIGH: r_zero_high <= i_cfg_data[DUR_W-1:0];
                CFG_ZERO_LOW:  r_zero_low  <= i_cfg_data[DUR_W-1:0];
                CFG_ONE_HIGH:  r_one_high  <= i_cfg_data[DUR_W-1:0];
                CFG_ONE_LOW:   r_one_low   <= i_cfg_data[DUR_W-1:0];
                CFG_LATCH_GAP: r_gap       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pixel store write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[addr_a] <= wdata;
        end
    end

    // entry valid bits, an invalid entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_valid <= '0;
        end else if (i_cmd.wr) begin
            r_valid[addr_a] <= 1'b1;
        end
    end

    // read port for get items
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_a) begin
            r_rda <= r_valid[addr_a] ? r_mem[addr_a] : '0;
        end
    end

    // prefetch read port, forwards a write or clear of this cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_rdb <= '0;
        end else if (i_cmd.wr && (addr_a == addr_b)) begin
            r_rdb <= wdata;
        end else begin
            r_rdb <= r_valid[addr_b] ? r_mem[addr_b] : '0;
        end
    end

    assign o_rd_data = r_rda;

    // bit timing compares against the tick count after this tick
    assign cur_bit = r_shift[PIX_BITS-1];
    assign hi_dur  = cur_bit ? r_one_high : r_zero_high;
    assign lo_dur  = cur_bit ? r_one_low : r_zero_low;
    assign n_tc    = r_tc + TICK_W'(1);

    always_comb begin
        o_status.idx_ok   = ({1'b0, i_pixel_index} < PIX_LIM);
        o_status.hi_done  = (n_tc >= TICK_W'(hi_dur));
        o_status.lo_done  = (n_tc >= TICK_W'(lo_dur));
        o_status.gap_done = (n_tc >= r_gap);
        o_status.last_bit = (r_bitcnt == BIT_LAST);
        o_status.last_pix = (r_pix == PIX_LAST);
    end

    // tick, bit and pixel counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc     <= '0;
            r_bitcnt <= '0;
            r_pix    <= PIX_LAST;
        end else begin
            if (i_cmd.start || i_cmd.tc_clr) begin
                r_tc <= '0;
            end else if (i_cmd.tc_inc) begin
                r_tc <= n_tc;
            end
            if (i_cmd.start) begin
                r_bitcnt <= '0;
                r_pix    <= '0;
            end else if (i_cmd.pix_next) begin
                r_bitcnt <= '0;
                r_pix    <= r_pix + PW'(1);
            end else if (i_cmd.bit_next) begin
                r_bitcnt <= r_bitcnt + BIT_CNT_W'(1);
            end
        end
    end

    // current pixel, sent msb first
    always_ff @(posedge i_clk) begin
        if (i_cmd.start || i_cmd.pix_next) begin
            r_shift <= r_rdb;
        end else if (i_cmd.bit_next) begin
            r_shift <= {r_shift[PIX_BITS-2:0], 1'b0};
        end
    end

endmodule

@@ rtl/ws2812_pixel_buffer_transmitter.sv @@
// Pixel buffer with a one-wire serial LED line encoder.
// Input channel (i_in_valid / o_in_stall) takes one item per cycle unless stalled: set,
// get, clear, flush or tick, with pixel index and color fields. Each item
// gives exactly one result on the output channel (o_out_valid / i_out_stall):
// line level, read color, dirty, busy and accepted flags.
// Results pass the read stage, then the output register; with no stall on the
// output the block sustains one item per clock. Each tick item moves the line
// encoder one step, so bit timing is counted in tick items, not clocks.
// The store is a memory with one read port for gets and one prefetch port
// that fetches the next pixel to send; clear zeroes all its valid bits.
// Configuration writes (i_cfg_valid / o_cfg_ready) set the four bit timing
// values and the latch gap, and are always taken; write them while idle.
// Reset: store reads as all zeros, line low, clean and idle, timing values
// back to defaults. There is no clearing pass.
// When the receiver stalls, the result waits in the output register, one
// more item can enter the read stage, and after that o_in_stall rises.
module ws2812_pixel_buffer_transmitter
    import wpb_pkg::*;
#(
    parameter int unsigned PIXELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_pixel_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_line_level,
    output logic [7:0]  o_read_red,
    output logic [7:0]  o_read_green,
    output logic [7:0]  o_read_blue,
    output logic        o_dirty,
    output logic        o_busy_res,
    output logic        o_accepted,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd                cmd;
    t_status             status;
    t_res                res;
    t_res                r_s1_res;
    logic                r_s1_valid;
    logic                r_out_valid;
    logic [PIX_BITS-1:0] rd_data;
    logic                accept_in;
    logic                s1_adv;

    // handshake
    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign accept_in   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    wpb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (accept_in),
        .i_op     (i_op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_res    (res)
    );

    wpb_datapath #(
        .PIXELS (PIXELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_index (i_pixel_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_rd_data     (rd_data)
    );

    // read stage: item flags wait here for the store read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept_in) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_res <= res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_line_level <= r_s1_res.line;
            o_dirty      <= r_s1_res.dirty;
            o_busy_res   <= r_s1_res.busy;
            o_accepted   <= r_s1_res.acc;
            o_read_red   <= r_s1_res.show_read ? rd_data[23:16] : 8'd0;
            o_read_green <= r_s1_res.show_read ? rd_data[15:8] : 8'd0;
            o_read_blue  <= r_s1_res.show_read ? rd_data[7:0] : 8'd0;
        end
    end

endmodule
